// ----- rtl/dtt_pkg.sv -----
// Shared types and codes for the delayed task table.
// Used by dtt_ctrl, dtt_datapath and delayed_task_table; no dependencies.
package dtt_pkg;

  typedef enum logic [2:0] {
    ACT_ADD        = 3'd0,
    ACT_REMOVE     = 3'd1,
    ACT_REMOVE_ALL = 3'd2,
    ACT_QUERY      = 3'd3,
    ACT_PROCESS    = 3'd4
  } dtt_action_e;

  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_PARAM  = 2'd1;
  localparam logic [1:0] STS_EXISTS = 2'd2;
  localparam logic [1:0] STS_FULL   = 2'd3;

  localparam logic [1:0] MODE_REFUSE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT,
    S_CLEAR,
    S_SEEK,
    S_FETCH,
    S_RESULT
  } dtt_state_e;

  typedef struct packed {
    logic load;
    logic ptr_clr;
    logic ptr_inc;
    logic scan_rd;
    logic commit;
    logic clr_all;
    logic fetch;
    logic out_single;
    logic out_fire;
  } dtt_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       ptr_last;
    logic       flag;
    logic       exp_zero;
    logic       exp_one;
    logic       out_free;
  } dtt_sts_t;

endpackage

// ----- rtl/dtt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/dtt_datapath.sv -----
// Slot storage, valid bits, match/expiry evaluation and result register.
// Depends on dtt_pkg and dtt_ram.
module dtt_datapath import dtt_pkg::*; #(
  parameter int SLOTS        = 16,
  parameter int TICK_BITS    = 32,
  parameter int HANDLER_BITS = 16,
  parameter int TOKEN_BITS   = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dtt_cmd_t                      cmd_i,
  output dtt_sts_t                      sts_o,
  input  logic [2:0]                    action_i,
  input  logic [HANDLER_BITS-1:0]       handler_i,
  input  logic [TOKEN_BITS-1:0]         token_i,
  input  logic                          diff_i,
  input  logic [1:0]                    mode_i,
  input  logic [TICK_BITS-1:0]          delay_i,
  input  logic [TICK_BITS-1:0]          now_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [1:0]                    out_status_o,
  output logic                          out_found_o,
  output logic                          out_fired_o,
  output logic [HANDLER_BITS-1:0]       out_handler_o,
  output logic [TOKEN_BITS-1:0]         out_token_o,
  output logic [$clog2(SLOTS+1)-1:0]    out_count_o,
  output logic                          out_last_o
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int HB = HANDLER_BITS;
  localparam int TB = TOKEN_BITS;
  localparam int KB = TICK_BITS;
  localparam int EW = HB + TB + 2 * KB;

  logic [2:0]    action_q;
  logic [HB-1:0] handler_q;
  logic [TB-1:0] token_q;
  logic          diff_q;
  logic [1:0]    mode_q;
  logic [KB-1:0] delay_q;
  logic [KB-1:0] now_q;

  logic [IW-1:0]    ptr_q, rd_idx_q, free_idx_q;
  logic             rd_en_q, fetch_q;
  logic [SLOTS-1:0] valid_q, exp_q;
  logic [CW-1:0]    cnt_q, exp_cnt_q;
  logic             refuse_q, found_q, free_found_q;

  logic          out_valid_q, out_found_q, out_fired_q, out_last_q;
  logic [1:0]    out_status_q;
  logic [HB-1:0] out_handler_q;
  logic [TB-1:0] out_token_q;
  logic [CW-1:0] out_count_q;

  logic [EW-1:0] rdata;
  logic [HB-1:0] r_h;
  logic [TB-1:0] r_t;
  logic [KB-1:0] r_s, r_w, elapsed;
  logic slot_v, hit_h, m_add, m_rq, expire;
  logic clr_add, clr_rm, clr_pr, slot_clr, free_here, commit_ok, do_commit;
  logic out_free;
  logic [1:0] single_status;

  dtt_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_slots (
    .clk_i   (clk_i),
    .we_i    (do_commit),
    .waddr_i (free_idx_q),
    .wdata_i ({delay_q, now_q, token_q, handler_q}),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  assign r_h = rdata[HB-1:0];
  assign r_t = rdata[HB +: TB];
  assign r_s = rdata[HB+TB +: KB];
  assign r_w = rdata[HB+TB+KB +: KB];

  always_comb begin
    slot_v    = valid_q[rd_idx_q];
    hit_h     = slot_v && (r_h == handler_q) && (handler_q != '0);
    m_add     = hit_h && (!diff_q || (r_t == token_q));
    m_rq      = hit_h && ((token_q == '0) || (r_t == token_q));
    elapsed   = now_q - r_s;
    expire    = slot_v && (elapsed >= r_w);
    clr_add   = (action_q == ACT_ADD) && (mode_q == MODE_CLEAR) && m_add;
    clr_rm    = (action_q == ACT_REMOVE) && m_rq;
    clr_pr    = (action_q == ACT_PROCESS) && expire;
    slot_clr  = rd_en_q && (clr_add || clr_rm || clr_pr);
    free_here = rd_en_q && (action_q == ACT_ADD) && (handler_q != '0) &&
                (!slot_v || clr_add) && !free_found_q;
    commit_ok = (handler_q != '0) && !((mode_q == MODE_REFUSE) && refuse_q) &&
                free_found_q;
    do_commit = cmd_i.commit && commit_ok;
    out_free  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    case (action_q)
      ACT_ADD: begin
        if (handler_q == '0) begin
          single_status = STS_PARAM;
        end else if ((mode_q == MODE_REFUSE) && refuse_q) begin
          single_status = STS_EXISTS;
        end else if (!free_found_q) begin
          single_status = STS_FULL;
        end else begin
          single_status = STS_OK;
        end
      end
      ACT_REMOVE, ACT_REMOVE_ALL, ACT_QUERY, ACT_PROCESS: single_status = STS_OK;
      default: single_status = STS_PARAM;
    endcase
  end

  // Command fields: captured on request accept.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q  <= action_i;
      handler_q <= handler_i;
      token_q   <= token_i;
      diff_q    <= diff_i;
      mode_q    <= mode_i;
      delay_q   <= delay_i;
      now_q     <= now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q        <= '0;
      rd_idx_q     <= '0;
      rd_en_q      <= 1'b0;
      fetch_q      <= 1'b0;
      valid_q      <= '0;
      exp_q        <= '0;
      cnt_q        <= '0;
      exp_cnt_q    <= '0;
      refuse_q     <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      rd_en_q  <= cmd_i.scan_rd;
      fetch_q  <= cmd_i.fetch;
      rd_idx_q <= ptr_q;

      if (cmd_i.load || cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= (ptr_q == IW'(SLOTS - 1)) ? '0 : ptr_q + 1'b1;
      end

      if (cmd_i.load) begin
        refuse_q     <= 1'b0;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
      end else if (rd_en_q) begin
        if (m_add) refuse_q <= 1'b1;
        if (m_rq) found_q <= 1'b1;
        if (free_here) begin
          free_found_q <= 1'b1;
          free_idx_q   <= rd_idx_q;
        end
      end

      if (cmd_i.clr_all) begin
        valid_q <= '0;
        cnt_q   <= '0;
      end else if (slot_clr) begin
        valid_q[rd_idx_q] <= 1'b0;
        cnt_q             <= cnt_q - 1'b1;
      end else if (do_commit) begin
        valid_q[free_idx_q] <= 1'b1;
        cnt_q               <= cnt_q + 1'b1;
      end

      if (rd_en_q && clr_pr) begin
        exp_q[rd_idx_q] <= 1'b1;
        exp_cnt_q       <= exp_cnt_q + 1'b1;
      end else if (fetch_q) begin
        exp_q[rd_idx_q] <= 1'b0;
        exp_cnt_q       <= exp_cnt_q - 1'b1;
      end

      if (cmd_i.out_single || cmd_i.out_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_single) begin
      out_status_q  <= single_status;
      out_found_q   <= (action_q == ACT_QUERY) && found_q;
      out_fired_q   <= 1'b0;
      out_handler_q <= '0;
      out_token_q   <= '0;
      out_count_q   <= cnt_q;
      out_last_q    <= 1'b1;
    end else if (cmd_i.out_fire) begin
      out_status_q  <= STS_OK;
      out_found_q   <= 1'b0;
      out_fired_q   <= 1'b1;
      out_handler_q <= r_h;
      out_token_q   <= r_t;
      out_count_q   <= cnt_q;
      out_last_q    <= (exp_cnt_q == CW'(1));
    end
  end

  assign sts_o.action   = action_q;
  assign sts_o.ptr_last = (ptr_q == IW'(SLOTS - 1));
  assign sts_o.flag     = exp_q[ptr_q];
  assign sts_o.exp_zero = (exp_cnt_q == '0);
  assign sts_o.exp_one  = (exp_cnt_q == CW'(1));
  assign sts_o.out_free = out_free;

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_found_o   = out_found_q;
  assign out_fired_o   = out_fired_q;
  assign out_handler_o = out_handler_q;
  assign out_token_o   = out_token_q;
  assign out_count_o   = out_count_q;
  assign out_last_o    = out_last_q;

  a_cnt_tracks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CW'($countones(valid_q)))
    else $error("active count out of step with valid bits");

  a_exp_cnt_tracks_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_cnt_q == CW'($countones(exp_q)))
    else $error("expired count out of step with expired flags");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_single || cmd_i.out_fire) |-> !(out_valid_q && !out_ready_i))
    else $error("result register overwritten before taken");

endmodule

// ----- rtl/dtt_ctrl.sv -----
// Sequencer for the delayed task table: scan, commit, clear and emit phases.
// Depends on dtt_pkg.
module dtt_ctrl import dtt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dtt_sts_t sts_i,
  input  logic [2:0] action_i,
  output dtt_cmd_t cmd_o
);

  dtt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (action_i)
            ACT_ADD, ACT_REMOVE, ACT_QUERY, ACT_PROCESS: state_d = S_SCAN;
            ACT_REMOVE_ALL: state_d = S_CLEAR;
            default: state_d = S_RESULT;
          endcase
        end
      end
      S_SCAN: begin
        if (sts_i.ptr_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        case (sts_i.action)
          ACT_ADD: state_d = S_COMMIT;
          ACT_PROCESS: state_d = S_SEEK;
          default: state_d = S_RESULT;
        endcase
      end
      S_COMMIT: state_d = S_RESULT;
      S_CLEAR: state_d = S_RESULT;
      S_SEEK: begin
        if (sts_i.exp_zero) begin
          state_d = S_RESULT;
        end else if (sts_i.flag && sts_i.out_free) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: state_d = sts_i.exp_one ? S_IDLE : S_SEEK;
      S_RESULT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        cmd_o.ptr_inc = 1'b1;
      end
      S_DRAIN: cmd_o.ptr_clr = 1'b1;
      S_COMMIT: cmd_o.commit = 1'b1;
      S_CLEAR: cmd_o.clr_all = 1'b1;
      S_SEEK: begin
        if (!sts_i.exp_zero) begin
          if (sts_i.flag) begin
            if (sts_i.out_free) begin
              cmd_o.fetch   = 1'b1;
              cmd_o.ptr_inc = 1'b1;
            end
          end else begin
            cmd_o.ptr_inc = 1'b1;
          end
        end
      end
      S_FETCH: cmd_o.out_fire = 1'b1;
      S_RESULT: cmd_o.out_single = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- rtl/delayed_task_table.sv -----
// Top level of the delayed task table: stream ports, controller and datapath.
// Depends on dtt_pkg, dtt_ctrl, dtt_datapath (and dtt_ram below it).
//
//  Channel  | Direction | Handshake                | Content
//  s_axis   | in        | s_axis_tvalid/tready     | one command request
//  m_axis   | out       | m_axis_tvalid/tready     | one result, tlast on the final one
//
// States from one request accept to the next: add goes through idle, a scan of
// every slot through the slot RAM read port, drain, commit and result; remove and
// query skip commit, remove-all takes idle, clear and result, an unknown code idle
// and result. A process command scans the same way, then walks the expired flags
// from slot 0 up to the last fired slot, one slot a cycle but held at a fired slot
// until m_axis is free, with a fetch step per fired task; result when none expired.
// Reset clears the valid bits, counters and state; slot contents need none.
// A result waits in the output register while the next request is accepted;
// a stalled m_axis holds the emit walk and the final result.
module delayed_task_table import dtt_pkg::*; #(
  parameter int SLOTS        = 16,
  parameter int TICK_BITS    = 32,
  parameter int HANDLER_BITS = 16,
  parameter int TOKEN_BITS   = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // handler_id, param_value, token_match, add_mode, delay, now (low bit up), zero pad
  input  logic [((HANDLER_BITS+TOKEN_BITS+3+2*TICK_BITS+7)/8)*8-1:0] s_axis_tdata,
  // action
  input  logic [2:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // status, found, fired, fired_handler, fired_param, slot_count (low bit up), zero pad
  output logic [((HANDLER_BITS+TOKEN_BITS+4+$clog2(SLOTS+1)+7)/8)*8-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  localparam int CW     = $clog2(SLOTS + 1);
  localparam int HB     = HANDLER_BITS;
  localparam int TB     = TOKEN_BITS;
  localparam int KB     = TICK_BITS;
  localparam int O_TOK  = HB;
  localparam int O_DIFF = HB + TB;
  localparam int O_MODE = O_DIFF + 1;
  localparam int O_DLY  = O_MODE + 2;
  localparam int O_NOW  = O_DLY + KB;
  localparam int OUT_W  = HB + TB + 4 + CW;
  localparam int OUT_PW = ((OUT_W + 7) / 8) * 8;

  dtt_cmd_t cmd;
  dtt_sts_t sts;

  logic [1:0]    r_status;
  logic          r_found, r_fired;
  logic [HB-1:0] r_handler;
  logic [TB-1:0] r_token;
  logic [CW-1:0] r_count;

  dtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .action_i   (s_axis_tuser),
    .cmd_o      (cmd)
  );

  dtt_datapath #(
    .SLOTS        (SLOTS),
    .TICK_BITS    (TICK_BITS),
    .HANDLER_BITS (HANDLER_BITS),
    .TOKEN_BITS   (TOKEN_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (s_axis_tuser),
    .handler_i     (s_axis_tdata[HB-1:0]),
    .token_i       (s_axis_tdata[O_TOK +: TB]),
    .diff_i        (s_axis_tdata[O_DIFF]),
    .mode_i        (s_axis_tdata[O_MODE +: 2]),
    .delay_i       (s_axis_tdata[O_DLY +: KB]),
    .now_i         (s_axis_tdata[O_NOW +: KB]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_status_o  (r_status),
    .out_found_o   (r_found),
    .out_fired_o   (r_fired),
    .out_handler_o (r_handler),
    .out_token_o   (r_token),
    .out_count_o   (r_count),
    .out_last_o    (m_axis_tlast)
  );

  // Pack result fields, lowest first, zero pad to whole bytes.
  assign m_axis_tdata = OUT_PW'({r_count, r_token, r_handler, r_fired, r_found, r_status});

endmodule

// ----- tb/delayed_task_table_tb.sv -----
// Self-checking testbench for delayed_task_table: stream requests, table predictor.
// Depends on dtt_pkg and the delayed_task_table RTL; needs no files at run time.
`timescale 1ns / 100ps

module delayed_task_table_tb;
  import dtt_pkg::*;

  localparam int SLOTS = 16;

  typedef struct {
    logic [2:0]  action;
    logic [15:0] handler;
    logic [31:0] token;
    logic        diff;
    logic [1:0]  mode;
    logic [31:0] dly;
    logic [31:0] now;
  } request_t;

  typedef struct {
    logic [1:0]  status;
    logic        found;
    logic        fired;
    logic [15:0] fired_handler;
    logic [31:0] fired_param;
    logic [4:0]  slot_count;
    logic        last;
  } outcome_t;

  // Shadow copy of the task table; predicts the outcomes of each request.
  class task_table_scoreboard;
    logic        occupied[SLOTS];
    logic [15:0] handler_of[SLOTS];
    logic [31:0] token_of[SLOTS];
    logic [31:0] start_of[SLOTS];
    logic [31:0] wait_of[SLOTS];
    outcome_t    pending_outcomes[$];
    int          mismatches;

    function new();
      mismatches = 0;
      foreach (occupied[i]) occupied[i] = 1'b0;
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction

    function outcome_t blank(logic [1:0] status);
      outcome_t o;
      o = '{status, 1'b0, 1'b0, 16'h0, 32'h0, 5'd0, 1'b0};
      return o;
    endfunction

    function void note_request(request_t r);
      outcome_t outs[$];
      outcome_t o;
      logic     hit;
      logic     placed;
      int       act;
      hit = 1'b0;
      case (r.action)
        ACT_ADD: begin
          if (r.handler == '0) begin
            outs.push_back(blank(STS_PARAM));
          end else begin
            foreach (occupied[i])
              if (occupied[i] && handler_of[i] == r.handler && (!r.diff || token_of[i] == r.token))
                hit = 1'b1;
            if (r.mode == MODE_REFUSE && hit) begin
              outs.push_back(blank(STS_EXISTS));
            end else begin
              // clear mode drops every match before looking for a free slot
              if (r.mode == MODE_CLEAR)
                foreach (occupied[i])
                  if (occupied[i] && handler_of[i] == r.handler &&
                      (!r.diff || token_of[i] == r.token))
                    occupied[i] = 1'b0;
              placed = 1'b0;
              foreach (occupied[i])
                if (!placed && !occupied[i]) begin
                  occupied[i] = 1'b1;
                  handler_of[i] = r.handler;
                  token_of[i] = r.token;
                  start_of[i] = r.now;
                  wait_of[i] = r.dly;
                  placed = 1'b1;
                end
              outs.push_back(blank(placed ? STS_OK : STS_FULL));
            end
          end
        end
        ACT_REMOVE: begin
          if (r.handler != '0)
            foreach (occupied[i])
              if (occupied[i] && handler_of[i] == r.handler &&
                  (r.token == '0 || token_of[i] == r.token))
                occupied[i] = 1'b0;
          outs.push_back(blank(STS_OK));
        end
        ACT_REMOVE_ALL: begin
          foreach (occupied[i]) occupied[i] = 1'b0;
          outs.push_back(blank(STS_OK));
        end
        ACT_QUERY: begin
          o = blank(STS_OK);
          if (r.handler != '0)
            foreach (occupied[i])
              if (occupied[i] && handler_of[i] == r.handler &&
                  (r.token == '0 || token_of[i] == r.token))
                o.found = 1'b1;
          outs.push_back(o);
        end
        ACT_PROCESS: begin
          // wrapping elapsed time; a zero wait always fires
          foreach (occupied[i])
            if (occupied[i] && (wait_of[i] == '0 || (r.now - start_of[i]) >= wait_of[i])) begin
              occupied[i] = 1'b0;
              o = blank(STS_OK);
              o.fired = 1'b1;
              o.fired_handler = handler_of[i];
              o.fired_param = token_of[i];
              outs.push_back(o);
            end
          if (outs.size() == 0) outs.push_back(blank(STS_OK));
        end
        default: outs.push_back(blank(STS_PARAM));
      endcase
      act = 0;
      foreach (occupied[i]) if (occupied[i]) act++;
      foreach (outs[k]) begin
        outs[k].slot_count = act[4:0];
        outs[k].last = (k == outs.size() - 1);
        pending_outcomes.push_back(outs[k]);
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
        return;
      end
      want = pending_outcomes.pop_front();
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tlast;

  task_table_scoreboard table_model = new();
  logic        idle_off;  // hold both sides busy for a stretch
  logic [31:0] tick;
  int          stall_left;

  delayed_task_table i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Result side: check each accepted result, then draw a stall for the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        table_model.check_result('{m_axis_tdata[1:0], m_axis_tdata[2], m_axis_tdata[3],
                                   m_axis_tdata[19:4], m_axis_tdata[51:20],
                                   m_axis_tdata[56:52], m_axis_tlast});
        stall_left = idle_off ? 0 : $urandom_range(0, 14);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Send one request after a random gap and advance once it is accepted.
  task send_request(request_t r);
    int gap;
    gap = idle_off ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.action;
    s_axis_tdata  <= {5'd0, r.now, r.dly, r.mode, r.diff, r.token, r.handler};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    table_model.note_request(r);
  endtask

  task send_fields(logic [2:0] action, logic [15:0] handler, logic [31:0] token,
                   logic diff, logic [1:0] mode, logic [31:0] dly, logic [31:0] now);
    request_t r;
    r = '{action, handler, token, diff, mode, dly, now};
    send_request(r);
  endtask

  // Random request biased toward a small handler and token pool so matches happen.
  function request_t random_request();
    request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 42) r.action = ACT_ADD;
    else if (pick < 67) r.action = ACT_PROCESS;
    else if (pick < 79) r.action = ACT_REMOVE;
    else if (pick < 92) r.action = ACT_QUERY;
    else if (pick < 96) r.action = ACT_REMOVE_ALL;
    else r.action = 3'($urandom_range(5, 7));
    pick = $urandom_range(0, 99);
    if (pick < 80) r.handler = 16'($urandom_range(1, 6));
    else if (pick < 90) r.handler = 16'($urandom);
    else if (pick < 95) r.handler = '0;
    else r.handler = 16'hFFFF;
    r.token = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3) : $urandom;
    r.diff = 1'($urandom_range(0, 1));
    r.mode = 2'($urandom_range(0, 3));
    r.dly = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 60) : $urandom;
    // advance the tick clock; now and then jump anywhere to exercise wrapping
    if ($urandom_range(0, 19) == 0) tick = $urandom;
    else tick = tick + $urandom_range(0, 20);
    r.now = tick;
    return r;
  endfunction

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ACT_ADD;
    m_axis_tready = 1'b0;
    stall_left = 0;
    idle_off = 1'b0;
    tick = 32'd100;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bad handler, extremes, refuse, plain mode three, clear mode, queries, remove.
    send_fields(ACT_ADD, 16'h0, 32'h5, 1'b0, 2'd0, 32'd1, 32'd0);
    send_fields(ACT_ADD, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fields(ACT_ADD, 16'hFFFF, 32'h1, 1'b0, MODE_REFUSE, 32'd0, 32'd0);
    send_fields(ACT_ADD, 16'hFFFF, 32'h1, 1'b1, MODE_REFUSE, 32'd0, 32'd0);
    send_fields(ACT_ADD, 16'hFFFF, 32'h1, 1'b0, 2'd3, 32'd0, 32'd0);
    send_fields(ACT_ADD, 16'hFFFF, 32'h1, 1'b1, MODE_CLEAR, 32'd5, 32'd0);
    send_fields(ACT_QUERY, 16'hFFFF, 32'h0, 1'b0, 2'd0, 32'd0, 32'd0);
    send_fields(ACT_QUERY, 16'h0, 32'h0, 1'b0, 2'd0, 32'd0, 32'd0);
    send_fields(ACT_QUERY, 16'hFFFF, 32'h7, 1'b0, 2'd0, 32'd0, 32'd0);
    send_fields(ACT_REMOVE, 16'h0, 32'h0, 1'b0, 2'd0, 32'd0, 32'd0);
    // process: wrapped elapsed time, nothing due yet
    send_fields(ACT_PROCESS, 16'h0, 32'h0, 1'b0, 2'd0, 32'd0, 32'd3);
    send_fields(ACT_REMOVE, 16'hFFFF, 32'h0, 1'b0, 2'd0, 32'd0, 32'd0);
    // fill the table, overflow it, then fire every slot at once
    for (int i = 0; i < SLOTS + 1; i++)
      send_fields(ACT_ADD, 16'(i + 1), 32'(i), 1'b0, 2'd0, 32'd2, 32'd10);
    send_fields(ACT_ADD, 16'd1, 32'd0, 1'b0, MODE_CLEAR, 32'd2, 32'd10);
    send_fields(ACT_PROCESS, 16'h0, 32'h0, 1'b0, 2'd0, 32'd0, 32'd12);
    send_fields(ACT_REMOVE_ALL, 16'h0, 32'h0, 1'b0, 2'd0, 32'd0, 32'd0);
    send_fields(3'd5, 16'h1, 32'h1, 1'b1, 2'd0, 32'd0, 32'd0);
    send_fields(3'd7, 16'h1, 32'h1, 1'b1, 2'd0, 32'd0, 32'd0);

    for (int n = 0; n < 450; n++) begin
      idle_off = (n >= 100 && n < 150);
      if (n == 250) begin
        // hold off the next request until the table has answered everything
        s_axis_tvalid <= 1'b0;
        while (table_model.pending() != 0) @(posedge clk_i);
      end
      send_request(random_request());
    end
    s_axis_tvalid <= 1'b0;

    while (table_model.pending() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (table_model.mismatches == 0) begin
      $display("[delayed_task_table] OK");
    end else begin
      $display("[delayed_task_table] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[delayed_task_table] ERROR");
    $finish;
  end

endmodule
